### design/pks_pkg.sv
`default_nettype none

package pks_pkg;

    localparam int Q_W      = 24;
    localparam int DT_W     = 16;
    localparam int LIM_W    = 23;
    localparam int NUM_AXES = 3;
    localparam int AXIS_W   = 2;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    // Shared multiplier: the wider operand is the acceleration or the low or upper
    // part of the velocity and acceleration sum, the other is the zero-extended time step.
    localparam int MUL_A_W = 26;
    localparam int MUL_B_W = DT_W + 1;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int W_W     = 42;
    localparam int SUM_W   = 28;
    localparam int UPC_W   = 4;

    typedef logic signed [Q_W-1:0] q_t;

    localparam logic [AXIS_W-1:0] AXIS_X    = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_Y    = 2'd1;
    localparam logic [AXIS_W-1:0] AXIS_Z    = 2'd2;
    localparam logic [AXIS_W-1:0] AXIS_LAST = AXIS_Z;

    localparam q_t POS_Z_RESET         = -24'sd393216;
    localparam q_t XY_LOW_RESET        = -24'sd196608;
    localparam q_t XY_HIGH_RESET       = 24'sd196608;
    localparam q_t Z_LOW_RESET         = -24'sd589824;
    localparam q_t Z_HIGH_RESET        = -24'sd196608;
    localparam logic [LIM_W-1:0] WRAP_INSET_RESET  = 23'd3277;
    localparam logic [LIM_W-1:0] SPEED_LIMIT_RESET = 23'd131072;
    localparam logic [LIM_W-1:0] Z_PUSH_RESET      = 23'd327680;

    typedef enum logic [2:0] {
        REG_XY_LOW,
        REG_XY_HIGH,
        REG_Z_LOW,
        REG_Z_HIGH,
        REG_WRAP_INSET,
        REG_SPEED_LIMIT,
        REG_Z_PUSH
    } reg_idx_t;

    typedef struct packed {
        logic signed [Q_W-1:0]  accel_x;
        logic signed [Q_W-1:0]  accel_y;
        logic signed [Q_W-1:0]  accel_z;
        logic        [DT_W-1:0] time_step;
    } step_item_t;

    typedef struct packed {
        logic signed [Q_W-1:0] pos_x;
        logic signed [Q_W-1:0] pos_y;
        logic signed [Q_W-1:0] pos_z;
        logic signed [Q_W-1:0] vel_x;
        logic signed [Q_W-1:0] vel_y;
        logic signed [Q_W-1:0] vel_z;
    } result_item_t;

    typedef enum logic [3:0] {
        UOP_MULA,
        UOP_VUPD,
        UOP_WSUM,
        UOP_MULL,
        UOP_MULH,
        UOP_ACC,
        UOP_PUPD,
        UOP_XYLO,
        UOP_XYHI,
        UOP_ZLO,
        UOP_ZHI,
        UOP_OUT
    } uop_t;

    typedef struct packed {
        uop_t              op;
        logic              fixed_axis;
        logic [AXIS_W-1:0] axis;
        logic              loop_back;
        logic [UPC_W-1:0]  target;
    } ucode_t;

    function automatic ucode_t mk_uword(input uop_t op, input logic fixed_axis,
                                        input logic [AXIS_W-1:0] axis,
                                        input logic loop_back,
                                        input logic [UPC_W-1:0] target);
        ucode_t w;
        w.op         = op;
        w.fixed_axis = fixed_axis;
        w.axis       = axis;
        w.loop_back  = loop_back;
        w.target     = target;
        return w;
    endfunction

    // Steps 0 to 6 run once per axis; the position step jumps back to the
    // start until the last axis is done. The bound checks follow in order.
    function automatic ucode_t ucode_rom(input logic [UPC_W-1:0] addr);
        ucode_t w;
        unique case (addr)
            4'd0:    w = mk_uword(UOP_MULA, 1'b0, AXIS_X, 1'b0, 4'd0);
            4'd1:    w = mk_uword(UOP_VUPD, 1'b0, AXIS_X, 1'b0, 4'd0);
            4'd2:    w = mk_uword(UOP_WSUM, 1'b0, AXIS_X, 1'b0, 4'd0);
            4'd3:    w = mk_uword(UOP_MULL, 1'b0, AXIS_X, 1'b0, 4'd0);
            4'd4:    w = mk_uword(UOP_MULH, 1'b0, AXIS_X, 1'b0, 4'd0);
            4'd5:    w = mk_uword(UOP_ACC,  1'b0, AXIS_X, 1'b0, 4'd0);
            4'd6:    w = mk_uword(UOP_PUPD, 1'b0, AXIS_X, 1'b1, 4'd0);
            4'd7:    w = mk_uword(UOP_XYLO, 1'b1, AXIS_X, 1'b0, 4'd0);
            4'd8:    w = mk_uword(UOP_XYHI, 1'b1, AXIS_X, 1'b0, 4'd0);
            4'd9:    w = mk_uword(UOP_XYLO, 1'b1, AXIS_Y, 1'b0, 4'd0);
            4'd10:   w = mk_uword(UOP_XYHI, 1'b1, AXIS_Y, 1'b0, 4'd0);
            4'd11:   w = mk_uword(UOP_ZLO,  1'b1, AXIS_Z, 1'b0, 4'd0);
            4'd12:   w = mk_uword(UOP_ZHI,  1'b1, AXIS_Z, 1'b0, 4'd0);
            default: w = mk_uword(UOP_OUT,  1'b1, AXIS_Z, 1'b0, 4'd0);
        endcase
        return w;
    endfunction

    function automatic q_t sat_q(input logic signed [SUM_W-1:0] x);
        logic signed [SUM_W-1:0] qmax;
        logic signed [SUM_W-1:0] qmin;
        qmax = 28'sd8388607;
        qmin = -28'sd8388608;
        if (x > qmax) begin
            return q_t'(qmax);
        end
        if (x < qmin) begin
            return q_t'(qmin);
        end
        return q_t'(x);
    endfunction

endpackage

`default_nettype wire

### design/pks_stream_if.sv
`default_nettype none

interface pks_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

### design/particle_kinematics_step.sv
// Moves one particle by one Euler step per transfer on the step channel: the
// item carries the acceleration on three axes and a time step, the block holds
// position and velocity, and each item yields one result with the new state.
// A small microcode program drives one shared 26 x 17 bit multiplier: an item
// runs through seven steps for each axis, then six bound checks and the result
// load, and the block takes no new item until that load is done. The result
// register lets a new item start while the previous result is still unread;
// the final load waits only if that result is still there. The user must write
// the configuration registers over the APB port only while no item is in
// progress; the block itself does not enforce this.

`default_nettype none

module particle_kinematics_step (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pks_pkg::ADDR_W-1:0]  paddr,
    input  logic [pks_pkg::DATA_W-1:0]  pwdata,
    output logic [pks_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    pks_stream_if.sink                  step,
    pks_stream_if.source                result
);
    import pks_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t state_reg, state_next;
    logic [UPC_W-1:0]  upc_reg, upc_next;
    logic [AXIS_W-1:0] axis_reg, axis_next;

    q_t              accel_reg [NUM_AXES];
    q_t              accel_next [NUM_AXES];
    logic [DT_W-1:0] dt_reg, dt_next;
    q_t              pos_reg [NUM_AXES];
    q_t              pos_next [NUM_AXES];
    q_t              vel_reg [NUM_AXES];
    q_t              vel_next [NUM_AXES];

    q_t                       tmp_reg, tmp_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [W_W-1:0]    w_reg, w_next;
    logic signed [PROD_W-1:0] acc_reg, acc_next;

    q_t               xy_low_reg, xy_low_next;
    q_t               xy_high_reg, xy_high_next;
    q_t               z_low_reg, z_low_next;
    q_t               z_high_reg, z_high_next;
    logic [LIM_W-1:0] wrap_inset_reg, wrap_inset_next;
    logic [LIM_W-1:0] speed_limit_reg, speed_limit_next;
    logic [LIM_W-1:0] z_push_reg, z_push_next;

    result_item_t out_reg, out_next;
    logic         out_valid_reg, out_valid_next;

    ucode_t                    uword;
    logic [AXIS_W-1:0]         ax;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  mul_p;

    logic signed [Q_W:0]     vel_ext;
    logic signed [Q_W:0]     lim_ext;
    q_t                      vel_clamped;
    q_t                      vel_upd;
    q_t                      pos_upd;
    q_t                      wrap_to_high;
    q_t                      wrap_to_low;
    q_t                      vz_pushed_up;
    q_t                      vz_pushed_down;
    logic signed [SUM_W-1:0] inset_ext;
    logic signed [SUM_W-1:0] push_ext;

    assign pready       = 1'b1;
    assign step.ready   = (state_reg == ST_IDLE);
    assign result.valid = out_valid_reg;
    assign result.payload = out_reg;

    assign uword = ucode_rom(upc_reg);
    assign ax    = uword.fixed_axis ? uword.axis : axis_reg;

    // The time step is unsigned, so it enters the signed multiplier with a
    // zero on top.
    assign mul_b = signed'({1'b0, dt_reg});
    assign mul_p = mul_a * mul_b;

    always_comb
    begin
        unique case (uword.op)
            UOP_MULA: mul_a = MUL_A_W'(accel_reg[ax]);
            UOP_MULL: mul_a = signed'(MUL_A_W'(w_reg[15:0]));
            UOP_MULH: mul_a = w_reg[W_W-1:16];
            default:  mul_a = '0;
        endcase
    end

    assign lim_ext   = signed'({2'b00, speed_limit_reg});
    assign vel_ext   = (Q_W+1)'(vel_reg[ax]);
    assign inset_ext = signed'(SUM_W'(wrap_inset_reg));
    assign push_ext  = signed'(SUM_W'(z_push_reg));

    always_comb
    begin
        if (vel_ext > lim_ext) begin
            vel_clamped = q_t'(lim_ext);
        end else if (vel_ext < -lim_ext) begin
            vel_clamped = q_t'(-lim_ext);
        end else begin
            vel_clamped = vel_reg[ax];
        end
    end

    // The product of acceleration and time step shifted down by 16 is its bits 39
    // to 16; the position change is the accumulated sum shifted by 17.
    assign vel_upd = sat_q(SUM_W'(tmp_reg) + SUM_W'(signed'(prod_reg[39:16])));
    assign pos_upd = sat_q(SUM_W'(pos_reg[ax]) + SUM_W'(signed'(acc_reg[PROD_W-1:17])));

    assign wrap_to_high   = sat_q(SUM_W'(xy_high_reg) - inset_ext);
    assign wrap_to_low    = sat_q(SUM_W'(xy_low_reg) + inset_ext);
    assign vz_pushed_up   = sat_q(SUM_W'(vel_reg[AXIS_Z]) + push_ext);
    assign vz_pushed_down = sat_q(SUM_W'(vel_reg[AXIS_Z]) - push_ext);

    always_comb
    begin
        unique case (paddr[ADDR_W-1:2])
            REG_XY_LOW:      prdata = DATA_W'(xy_low_reg);
            REG_XY_HIGH:     prdata = DATA_W'(xy_high_reg);
            REG_Z_LOW:       prdata = DATA_W'(z_low_reg);
            REG_Z_HIGH:      prdata = DATA_W'(z_high_reg);
            REG_WRAP_INSET:  prdata = DATA_W'(wrap_inset_reg);
            REG_SPEED_LIMIT: prdata = DATA_W'(speed_limit_reg);
            REG_Z_PUSH:      prdata = DATA_W'(z_push_reg);
            default:         prdata = '0;
        endcase
    end

    always_comb
    begin
        state_next       = state_reg;
        upc_next         = upc_reg;
        axis_next        = axis_reg;
        accel_next       = accel_reg;
        dt_next          = dt_reg;
        pos_next         = pos_reg;
        vel_next         = vel_reg;
        tmp_next         = tmp_reg;
        prod_next        = prod_reg;
        w_next           = w_reg;
        acc_next         = acc_reg;
        xy_low_next      = xy_low_reg;
        xy_high_next     = xy_high_reg;
        z_low_next       = z_low_reg;
        z_high_next      = z_high_reg;
        wrap_inset_next  = wrap_inset_reg;
        speed_limit_next = speed_limit_reg;
        z_push_next      = z_push_reg;
        out_next         = out_reg;
        out_valid_next   = out_valid_reg;

        if (psel && penable && pwrite) begin
            unique case (paddr[ADDR_W-1:2])
                REG_XY_LOW:      xy_low_next      = pwdata[Q_W-1:0];
                REG_XY_HIGH:     xy_high_next     = pwdata[Q_W-1:0];
                REG_Z_LOW:       z_low_next       = pwdata[Q_W-1:0];
                REG_Z_HIGH:      z_high_next      = pwdata[Q_W-1:0];
                REG_WRAP_INSET:  wrap_inset_next  = pwdata[LIM_W-1:0];
                REG_SPEED_LIMIT: speed_limit_next = pwdata[LIM_W-1:0];
                REG_Z_PUSH:      z_push_next      = pwdata[LIM_W-1:0];
                default:         ;
            endcase
        end

        if (result.valid && result.ready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (step.valid) begin
                    accel_next[AXIS_X] = step.payload.accel_x;
                    accel_next[AXIS_Y] = step.payload.accel_y;
                    accel_next[AXIS_Z] = step.payload.accel_z;
                    dt_next            = step.payload.time_step;
                    upc_next           = '0;
                    axis_next          = AXIS_X;
                    state_next         = ST_RUN;
                end
            end
            ST_RUN:
            begin
                unique case (uword.op)
                    UOP_MULA:
                    begin
                        prod_next = mul_p;
                        tmp_next  = vel_clamped;
                    end
                    UOP_VUPD:
                    begin
                        vel_next[ax] = vel_upd;
                        w_next       = W_W'(signed'(prod_reg[39:0]));
                    end
                    UOP_WSUM:
                    begin
                        w_next = w_reg + W_W'(signed'({vel_reg[ax], 17'b0}));
                    end
                    UOP_MULL:
                    begin
                        prod_next = mul_p;
                    end
                    UOP_MULH:
                    begin
                        prod_next = mul_p;
                        acc_next  = signed'(PROD_W'(prod_reg[31:16]));
                    end
                    UOP_ACC:
                    begin
                        acc_next = prod_reg + acc_reg;
                    end
                    UOP_PUPD:
                    begin
                        pos_next[ax] = pos_upd;
                    end
                    UOP_XYLO:
                    begin
                        if (pos_reg[ax] < xy_low_reg) begin
                            pos_next[ax] = wrap_to_high;
                        end
                    end
                    UOP_XYHI:
                    begin
                        if (pos_reg[ax] > xy_high_reg) begin
                            pos_next[ax] = wrap_to_low;
                        end
                    end
                    UOP_ZLO:
                    begin
                        if (pos_reg[AXIS_Z] < z_low_reg) begin
                            vel_next[AXIS_Z] = vz_pushed_up;
                        end
                    end
                    UOP_ZHI:
                    begin
                        if (pos_reg[AXIS_Z] > z_high_reg) begin
                            vel_next[AXIS_Z] = vz_pushed_down;
                        end
                    end
                    UOP_OUT:
                    begin
                        if (!out_valid_reg || result.ready) begin
                            out_next.pos_x = pos_reg[AXIS_X];
                            out_next.pos_y = pos_reg[AXIS_Y];
                            out_next.pos_z = pos_reg[AXIS_Z];
                            out_next.vel_x = vel_reg[AXIS_X];
                            out_next.vel_y = vel_reg[AXIS_Y];
                            out_next.vel_z = vel_reg[AXIS_Z];
                            out_valid_next = 1'b1;
                            state_next     = ST_IDLE;
                        end
                    end
                    default: ;
                endcase

                if (uword.op != UOP_OUT) begin
                    if (uword.loop_back && (axis_reg != AXIS_LAST)) begin
                        upc_next  = uword.target;
                        axis_next = AXIS_W'(axis_reg + 2'd1);
                    end else begin
                        upc_next = UPC_W'(upc_reg + 4'd1);
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg       <= ST_IDLE;
            upc_reg         <= '0;
            axis_reg        <= AXIS_X;
            accel_reg       <= '{default: '0};
            dt_reg          <= '0;
            pos_reg         <= '{24'sd0, 24'sd0, POS_Z_RESET};
            vel_reg         <= '{default: '0};
            tmp_reg         <= '0;
            prod_reg        <= '0;
            w_reg           <= '0;
            acc_reg         <= '0;
            xy_low_reg      <= XY_LOW_RESET;
            xy_high_reg     <= XY_HIGH_RESET;
            z_low_reg       <= Z_LOW_RESET;
            z_high_reg      <= Z_HIGH_RESET;
            wrap_inset_reg  <= WRAP_INSET_RESET;
            speed_limit_reg <= SPEED_LIMIT_RESET;
            z_push_reg      <= Z_PUSH_RESET;
            out_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            state_reg       <= state_next;
            upc_reg         <= upc_next;
            axis_reg        <= axis_next;
            accel_reg       <= accel_next;
            dt_reg          <= dt_next;
            pos_reg         <= pos_next;
            vel_reg         <= vel_next;
            tmp_reg         <= tmp_next;
            prod_reg        <= prod_next;
            w_reg           <= w_next;
            acc_reg         <= acc_next;
            xy_low_reg      <= xy_low_next;
            xy_high_reg     <= xy_high_next;
            z_low_reg       <= z_low_next;
            z_high_reg      <= z_high_next;
            wrap_inset_reg  <= wrap_inset_next;
            speed_limit_reg <= speed_limit_next;
            z_push_reg      <= z_push_next;
            out_reg         <= out_next;
            out_valid_reg   <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

### design/pks_checker.sv
`default_nettype none

module pks_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  step_valid,
    input logic                  step_ready,
    input logic                  result_valid,
    input logic                  result_ready,
    input pks_pkg::result_item_t result_payload
);

    // A pending result stays offered until it is taken.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result dropped before transfer");

    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> $stable(result_payload))
        else $error("result payload changed while stalled");

    // One item is worked on at a time, so the channel closes after a transfer.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        step_valid && step_ready |=> !step_ready)
        else $error("step channel still open after a transfer");

    // The microcode runs all its steps before the result load, so no result can appear right away.
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        step_valid && step_ready |=> ##1 !$rose(result_valid))
        else $error("result appeared too soon after a transfer");

endmodule

bind particle_kinematics_step pks_checker u_pks_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .step_valid     (step.valid),
    .step_ready     (step.ready),
    .result_valid   (result.valid),
    .result_ready   (result.ready),
    .result_payload (result.payload)
);

`default_nettype wire
